>>> rtl/yuvb_pkg.sv
// ----------------------------------------------------------------------------
// yuvb_pkg: shared types and constants of the YUV pair to BGRA converter
// Field structs for both channels, register indexes and reset values, and
// the fixed-point helper functions used by the arithmetic stages.
// ----------------------------------------------------------------------------
package yuvb_pkg;

    // Fixed-point format and sample width.
    localparam int FRAC_BITS   = 16;
    localparam int SAMPLE_BITS = 10;

    // Widths fixed by the channel and register definitions.
    localparam int FIELD_W  = 10;
    localparam int COUNT_W  = 2;
    localparam int COEF_W   = 18;
    localparam int OFFSET_W = 10;
    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_W;

    // Offset sample: wide enough for any sample minus any offset.
    localparam int SAMP_W = (SAMPLE_BITS > FIELD_W) ? SAMPLE_BITS : FIELD_W;
    localparam int DIFF_W = ((SAMP_W > OFFSET_W) ? SAMP_W : OFFSET_W) + 1;
    // Signed product of an unsigned coefficient and an offset sample.
    localparam int PROD_W = COEF_W + 1 + DIFF_W;
    // Sum of up to three products plus the rounding half.
    localparam int SUM_W  = PROD_W + 2;

    localparam logic [SAMP_W-1:0] SAMPLE_MASK = SAMP_W'((2 ** SAMPLE_BITS) - 1);
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(2 ** (FRAC_BITS - 1));
    localparam logic [BYTE_W-1:0] CHANNEL_MAX = 8'd255;
    localparam logic [BYTE_W-1:0] ALPHA_VALUE = 8'd255;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_FROM_V    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_FROM_U  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_FROM_V  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_FROM_U   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_OFFSET   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_OFFSET = 3'd6;

    // Reset values: full-range BT.709, 8-bit.
    localparam logic [COEF_W-1:0]   RST_LUMA_GAIN     = 18'd65536;
    localparam logic [COEF_W-1:0]   RST_RED_FROM_V    = 18'd103206;
    localparam logic [COEF_W-1:0]   RST_GREEN_FROM_U  = 18'd12276;
    localparam logic [COEF_W-1:0]   RST_GREEN_FROM_V  = 18'd30679;
    localparam logic [COEF_W-1:0]   RST_BLUE_FROM_U   = 18'd121609;
    localparam logic [OFFSET_W-1:0] RST_LUMA_OFFSET   = 10'd0;
    localparam logic [OFFSET_W-1:0] RST_CHROMA_OFFSET = 10'd128;

    typedef struct packed {
        logic [FIELD_W-1:0] luma_first;
        logic [FIELD_W-1:0] luma_second;
        logic [FIELD_W-1:0] chroma_u;
        logic [FIELD_W-1:0] chroma_v;
        logic [COUNT_W-1:0] pair_count;
    } t_yuv_in;

    typedef struct packed {
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] alpha;
        logic              last_of_run;
    } t_bgra_out;

    // One pixel as handed from the issue stage to the arithmetic stages.
    typedef struct packed {
        logic               valid;
        logic [FIELD_W-1:0] luma;
        logic [FIELD_W-1:0] chroma_u;
        logic [FIELD_W-1:0] chroma_v;
        logic               last;
    } t_pix;

    // Sample taken in its low SAMPLE_BITS bits, minus an offset.
    function automatic logic signed [DIFF_W-1:0] sample_diff(
        input logic [FIELD_W-1:0]  sample,
        input logic [OFFSET_W-1:0] offset
    );
        logic [SAMP_W-1:0] s;
        s = SAMP_W'(sample) & SAMPLE_MASK;
        return signed'(DIFF_W'(s) - DIFF_W'(offset));
    endfunction

    function automatic logic signed [PROD_W-1:0] coef_mul(
        input logic [COEF_W-1:0]        coef,
        input logic signed [DIFF_W-1:0] diff
    );
        logic signed [PROD_W-1:0] c;
        logic signed [PROD_W-1:0] d;
        c = PROD_W'(signed'({1'b0, coef}));
        d = PROD_W'(diff);
        return c * d;
    endfunction

    // Takes a sum that already carries the rounding half.
    function automatic logic [BYTE_W-1:0] to_byte(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] sh;
        logic [BYTE_W-1:0]       b;
        sh = v >>> FRAC_BITS;
        if (v < 0) begin
            b = '0;
        end else if (sh >= signed'(SUM_W'(CHANNEL_MAX))) begin
            b = CHANNEL_MAX;
        end else begin
            b = sh[BYTE_W-1:0];
        end
        return b;
    endfunction

endpackage

>>> rtl/yuvb_issue.sv
// ----------------------------------------------------------------------------
// yuvb_issue: input buffer and pixel issue
// Holds one accepted chroma pair and hands its one or two pixels to the
// arithmetic pipeline, one pixel per advancing cycle.
// ----------------------------------------------------------------------------
module yuvb_issue
    import yuvb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_yuv_in i_in,
    output logic    o_stall,
    input  logic    i_adv,
    output t_pix    o_pix
);

    logic    r_full;
    logic    r_second;
    t_yuv_in r_item;
    logic    n_full;
    logic    n_second;
    t_yuv_in n_item;

    logic is_last;
    logic release_item;
    logic accept;

    // A count of three saturates to two pixels; a count of one is a lone pixel.
    assign is_last      = r_second || !r_item.pair_count[1];
    assign release_item = i_adv && r_full && is_last;
    assign o_stall      = r_full && !release_item;
    assign accept       = i_valid && !o_stall;

    assign o_pix.valid    = r_full;
    assign o_pix.luma     = r_second ? r_item.luma_second : r_item.luma_first;
    assign o_pix.chroma_u = r_item.chroma_u;
    assign o_pix.chroma_v = r_item.chroma_v;
    assign o_pix.last     = is_last;

    always_comb begin
        n_full   = r_full;
        n_second = r_second;
        n_item   = r_item;
        // A transaction with a pair count of zero is taken and dropped.
        if (accept && (i_in.pair_count != '0)) begin
            n_full   = 1'b1;
            n_second = 1'b0;
            n_item   = i_in;
        end else if (release_item) begin
            n_full   = 1'b0;
            n_second = 1'b0;
        end else if (i_adv && r_full) begin
            n_second = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full   <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_full   <= n_full;
            r_second <= n_second;
        end
        r_item <= n_item;
    end

endmodule

>>> rtl/yuv_pair_to_bgra_fixed.sv
// ----------------------------------------------------------------------------
// yuv_pair_to_bgra_fixed: YUV chroma pair to BGRA pixel converter
// Converts one or two luma samples with a shared U/V pair into clamped
// BGRA pixels using unsigned 2.16 fixed-point coefficients held in registers.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_valid, i_in, o_stall) takes one transaction per chroma
// pair: two luma samples, U, V and a pair count. The output channel (o_valid,
// o_out, i_stall) delivers one BGRA pixel per transaction, with last_of_run
// set on the final pixel of each input. A pair count of zero produces no
// pixel; a count of three is treated as two.
// The pipeline issues one pixel per cycle while the output register is not
// stalled, so a two-pixel input holds the input buffer while both pixels
// issue, and the next input is taken in the cycle the last pixel issues;
// the single pixel issue port sets the input rate.
// Stages: input buffer, offset subtraction, five multipliers, channel sums
// with rounding, clamp into the output register.
// When the receiver stalls a valid output pixel, the whole pipeline holds and
// o_stall rises once the input buffer is occupied; nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and loads the full-range
// BT.709 coefficients. The user must write registers through i_cfg_we, i_cfg_index
// and i_cfg_data only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module yuv_pair_to_bgra_fixed
    import yuvb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_yuv_in               i_in,
    output logic                  o_stall,
    output logic                  o_valid,
    output t_bgra_out             o_out,
    input  logic                  i_stall,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic [COEF_W-1:0]   r_luma_gain;
    logic [COEF_W-1:0]   r_red_from_v;
    logic [COEF_W-1:0]   r_green_from_u;
    logic [COEF_W-1:0]   r_green_from_v;
    logic [COEF_W-1:0]   r_blue_from_u;
    logic [OFFSET_W-1:0] r_luma_offset;
    logic [OFFSET_W-1:0] r_chroma_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_luma_gain     <= RST_LUMA_GAIN;
            r_red_from_v    <= RST_RED_FROM_V;
            r_green_from_u  <= RST_GREEN_FROM_U;
            r_green_from_v  <= RST_GREEN_FROM_V;
            r_blue_from_u   <= RST_BLUE_FROM_U;
            r_luma_offset   <= RST_LUMA_OFFSET;
            r_chroma_offset <= RST_CHROMA_OFFSET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LUMA_GAIN:     r_luma_gain     <= i_cfg_data;
                CFG_RED_FROM_V:    r_red_from_v    <= i_cfg_data;
                CFG_GREEN_FROM_U:  r_green_from_u  <= i_cfg_data;
                CFG_GREEN_FROM_V:  r_green_from_v  <= i_cfg_data;
                CFG_BLUE_FROM_U:   r_blue_from_u   <= i_cfg_data;
                CFG_LUMA_OFFSET:   r_luma_offset   <= i_cfg_data[OFFSET_W-1:0];
                CFG_CHROMA_OFFSET: r_chroma_offset <= i_cfg_data[OFFSET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // All stages move together unless the output register holds a stalled pixel.
    logic adv;
    t_pix pix;

    yuvb_issue u_issue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_in    (i_in),
        .o_stall (o_stall),
        .i_adv   (adv),
        .o_pix   (pix)
    );

    // Stage 2: offsets removed.
    logic                     r_v2;
    logic                     r_last2;
    logic signed [DIFF_W-1:0] r_yd2;
    logic signed [DIFF_W-1:0] r_ud2;
    logic signed [DIFF_W-1:0] r_vd2;

    // Stage 3: products.
    logic                     r_v3;
    logic                     r_last3;
    logic signed [PROD_W-1:0] r_luma3;
    logic signed [PROD_W-1:0] r_blue3;
    logic signed [PROD_W-1:0] r_gu3;
    logic signed [PROD_W-1:0] r_gv3;
    logic signed [PROD_W-1:0] r_red3;

    // Stage 4: rounded channel sums.
    logic                    r_v4;
    logic                    r_last4;
    logic signed [SUM_W-1:0] r_bsum4;
    logic signed [SUM_W-1:0] r_gsum4;
    logic signed [SUM_W-1:0] r_rsum4;

    // Stage 5: output register.
    logic      r_v5;
    t_bgra_out r_out5;

    assign adv     = !(r_v5 && i_stall);
    assign o_valid = r_v5;
    assign o_out   = r_out5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (adv) begin
            r_v2 <= pix.valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_last2 <= pix.last;
            r_yd2   <= sample_diff(pix.luma, r_luma_offset);
            r_ud2   <= sample_diff(pix.chroma_u, r_chroma_offset);
            r_vd2   <= sample_diff(pix.chroma_v, r_chroma_offset);

            r_last3 <= r_last2;
            r_luma3 <= coef_mul(r_luma_gain, r_yd2);
            r_blue3 <= coef_mul(r_blue_from_u, r_ud2);
            r_gu3   <= coef_mul(r_green_from_u, r_ud2);
            r_gv3   <= coef_mul(r_green_from_v, r_vd2);
            r_red3  <= coef_mul(r_red_from_v, r_vd2);

            r_last4 <= r_last3;
            r_bsum4 <= SUM_W'(r_luma3) + SUM_W'(r_blue3) + ROUND_HALF;
            r_gsum4 <= SUM_W'(r_luma3) - SUM_W'(r_gu3) - SUM_W'(r_gv3) + ROUND_HALF;
            r_rsum4 <= SUM_W'(r_luma3) + SUM_W'(r_red3) + ROUND_HALF;

            r_out5.blue        <= to_byte(r_bsum4);
            r_out5.green       <= to_byte(r_gsum4);
            r_out5.red         <= to_byte(r_rsum4);
            r_out5.alpha       <= ALPHA_VALUE;
            r_out5.last_of_run <= r_last4;
        end
    end

endmodule

>>> dv/tb_yuv_pair_to_bgra_fixed.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_yuv_pair_to_bgra_fixed: self-checking bench for the YUV pair converter
// A queue-fed driver sends chroma-pair transactions in random bursts while
// the receiver stalls on its own pattern. Every accepted input is run
// through a local fixed-point predictor, and each output pixel is checked
// field by field against the oldest predicted pixel. Between phases the
// bench drains the pipeline and loads a new coefficient and offset setting.
// ----------------------------------------------------------------------------
module tb_yuv_pair_to_bgra_fixed
    import yuvb_pkg::*;
();

    localparam int HALF_PERIOD     = 2;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 185;
    localparam int SETTLE_CYCLES   = 12;
    localparam int REPORT_LIMIT    = 25;
    localparam int TIMEOUT_NS      = 4_000_000;
    localparam int BYTE_TOP        = 255;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
    localparam logic [COEF_W-1:0]    COEF_TOP   = '1;
    localparam logic [FIELD_W-1:0]   SAMPLE_TOP = '1;
    localparam logic [FIELD_W-1:0]   SAMPLE_SEL = FIELD_W'((1 << SAMPLE_BITS) - 1);

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_RUNS} t_rx_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    t_yuv_in               i_in        = '0;
    logic                  o_stall;
    logic                  o_valid;
    t_bgra_out             o_out;
    logic                  i_stall     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    yuv_pair_to_bgra_fixed dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_in        (i_in),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_out       (o_out),
        .i_stall     (i_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Local copy of the register file.
    logic [COEF_W-1:0]   luma_gain_r     = RST_LUMA_GAIN;
    logic [COEF_W-1:0]   red_from_v_r    = RST_RED_FROM_V;
    logic [COEF_W-1:0]   green_from_u_r  = RST_GREEN_FROM_U;
    logic [COEF_W-1:0]   green_from_v_r  = RST_GREEN_FROM_V;
    logic [COEF_W-1:0]   blue_from_u_r   = RST_BLUE_FROM_U;
    logic [OFFSET_W-1:0] luma_offset_r   = RST_LUMA_OFFSET;
    logic [OFFSET_W-1:0] chroma_offset_r = RST_CHROMA_OFFSET;

    t_yuv_in   pending_q[$];
    t_bgra_out expected_pixels[$];

    int accepted_cnt   = 0;
    int issued_cnt     = 0;
    int pixels_checked = 0;
    int errors         = 0;
    int settings_used  = 1;
    int empty_cnt      = 0;
    int single_cnt     = 0;
    int pair_cnt       = 0;
    int saturated_cnt  = 0;

    // ------------------------------------------------------------------
    // Pixel predictor
    // ------------------------------------------------------------------
    function automatic logic [BYTE_W-1:0] clamp_channel(input longint sum);
        longint r;
        r = sum + (longint'(1) <<< (FRAC_BITS - 1));
        if (r < 0) return '0;
        r = r >>> FRAC_BITS;
        if (r >= BYTE_TOP) return BYTE_W'(BYTE_TOP);
        return r[BYTE_W-1:0];
    endfunction

    task automatic predict_pixels(input t_yuv_in item);
        longint    u, v, b_term, g_term, r_term, luma;
        int        n;
        logic [FIELD_W-1:0] y;
        t_bgra_out px;
        if (item.pair_count == 2'd0) return;
        n = (item.pair_count >= 2'd2) ? 2 : 1;
        u = longint'(item.chroma_u & SAMPLE_SEL) - longint'(chroma_offset_r);
        v = longint'(item.chroma_v & SAMPLE_SEL) - longint'(chroma_offset_r);
        b_term = longint'(blue_from_u_r) * u;
        g_term = -(longint'(green_from_u_r) * u) - longint'(green_from_v_r) * v;
        r_term = longint'(red_from_v_r) * v;
        for (int k = 0; k < n; k++) begin
            y = (k == 0) ? item.luma_first : item.luma_second;
            luma = longint'(luma_gain_r) *
                   (longint'(y & SAMPLE_SEL) - longint'(luma_offset_r));
            px.blue        = clamp_channel(luma + b_term);
            px.green       = clamp_channel(luma + g_term);
            px.red         = clamp_channel(luma + r_term);
            px.alpha       = BYTE_W'(BYTE_TOP);
            px.last_of_run = (k == n - 1);
            expected_pixels.push_back(px);
        end
    endtask

    // ------------------------------------------------------------------
    // Acceptance and output check, both sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_bgra_out want;
        string     want_s;
        string     got_s;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                accepted_cnt++;
                case (i_in.pair_count)
                    2'd0:    empty_cnt++;
                    2'd1:    single_cnt++;
                    2'd2:    pair_cnt++;
                    default: saturated_cnt++;
                endcase
                predict_pixels(i_in);
            end
            if (o_valid && !i_stall) begin
                if (expected_pixels.size() == 0) begin
                    if (errors < REPORT_LIMIT)
                        $display("%0t: unexpected pixel B=%0d G=%0d R=%0d A=%0d last=%0d",
                                 $time, o_out.blue, o_out.green, o_out.red,
                                 o_out.alpha, o_out.last_of_run);
                    errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    pixels_checked++;
                    if (o_out.blue !== want.blue || o_out.green !== want.green ||
                        o_out.red !== want.red || o_out.alpha !== want.alpha ||
                        o_out.last_of_run !== want.last_of_run) begin
                        if (errors < REPORT_LIMIT) begin
                            want_s = $sformatf("B=%0d G=%0d R=%0d A=%0d last=%0d",
                                               want.blue, want.green, want.red,
                                               want.alpha, want.last_of_run);
                            got_s  = $sformatf("B=%0d G=%0d R=%0d A=%0d last=%0d",
                                               o_out.blue, o_out.green, o_out.red,
                                               o_out.alpha, o_out.last_of_run);
                            $display("%0t: pixel mismatch: expected %s, got %s",
                                     $time, want_s, got_s);
                        end
                        errors++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    int gap_left   = 0;
    int burst_left = 8;

    always @(negedge i_clk) begin : tx_drive
        // A transaction still waiting for acceptance is held unchanged.
        if (i_rst_n && !(i_valid && accepted_cnt != issued_cnt)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_q.size() == 0) begin
                i_valid <= 1'b0;
            end else begin
                i_in    <= pending_q.pop_front();
                i_valid <= 1'b1;
                issued_cnt++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30)
                                                             : $urandom_range(0, 6);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure, switching between several patterns
    // ------------------------------------------------------------------
    t_rx_mode rx_mode   = RX_FREE;
    int       mode_left = 40;
    int       run_left  = 0;
    logic     run_level = 1'b0;

    always @(negedge i_clk) begin : rx_pace
        if (mode_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        case (rx_mode)
            RX_FREE:  i_stall <= 1'b0;
            RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default: begin
                if (run_left == 0) begin
                    run_level = ~run_level;
                    run_left  = $urandom_range(1, 16);
                end else begin
                    run_left--;
                end
                i_stall <= run_level;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic [FIELD_W-1:0] l1, input logic [FIELD_W-1:0] l2,
                             input logic [FIELD_W-1:0] u, input logic [FIELD_W-1:0] v,
                             input logic [COUNT_W-1:0] cnt);
        t_yuv_in it;
        it.luma_first  = l1;
        it.luma_second = l2;
        it.chroma_u    = u;
        it.chroma_v    = v;
        it.pair_count  = cnt;
        pending_q.push_back(it);
    endtask

    function automatic logic [FIELD_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SAMPLE_TOP;
            default: return FIELD_W'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef(input logic [COEF_W-1:0] nominal);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return COEF_TOP;
            2:       return nominal;
            3, 4:    return COEF_W'($urandom_range(0, 2 * nominal));
            default: return COEF_W'($urandom_range(0, COEF_TOP));
        endcase
    endfunction

    // Offsets travel with random upper bits, which the register drops.
    function automatic logic [CFG_DATA_W-1:0] rand_offset();
        logic [OFFSET_W-1:0] off;
        case ($urandom_range(0, 5))
            0:       off = '0;
            1:       off = '1;
            2:       off = 10'd64;
            3:       off = 10'd512;
            default: off = OFFSET_W'($urandom_range(0, 1023));
        endcase
        return {8'($urandom), off};
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_LUMA_GAIN:     luma_gain_r     = data;
            CFG_RED_FROM_V:    red_from_v_r    = data;
            CFG_GREEN_FROM_U:  green_from_u_r  = data;
            CFG_GREEN_FROM_V:  green_from_v_r  = data;
            CFG_BLUE_FROM_U:   blue_from_u_r   = data;
            CFG_LUMA_OFFSET:   luma_offset_r   = data[OFFSET_W-1:0];
            CFG_CHROMA_OFFSET: chroma_offset_r = data[OFFSET_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until everything sent has been accepted and every predicted pixel
    // has come out, then lets the pipeline settle.
    task automatic drain();
        while (pending_q.size() != 0 || accepted_cnt != issued_cnt ||
               expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_setting(input int phase);
        case (phase)
            1: begin
                write_reg(CFG_LUMA_GAIN,     COEF_TOP);
                write_reg(CFG_RED_FROM_V,    COEF_TOP);
                write_reg(CFG_GREEN_FROM_U,  COEF_TOP);
                write_reg(CFG_GREEN_FROM_V,  COEF_TOP);
                write_reg(CFG_BLUE_FROM_U,   COEF_TOP);
                write_reg(CFG_LUMA_OFFSET,   '1);
                write_reg(CFG_CHROMA_OFFSET, '1);
                // Index past the register list must change nothing.
                write_reg(CFG_NO_REG,        CFG_DATA_W'($urandom));
            end
            2: begin
                write_reg(CFG_LUMA_GAIN,     '0);
                write_reg(CFG_RED_FROM_V,    '0);
                write_reg(CFG_GREEN_FROM_U,  '0);
                write_reg(CFG_GREEN_FROM_V,  '0);
                write_reg(CFG_BLUE_FROM_U,   '0);
                write_reg(CFG_LUMA_OFFSET,   '0);
                write_reg(CFG_CHROMA_OFFSET, '0);
            end
            3: begin
                // Limited-range 10-bit video.
                write_reg(CFG_LUMA_GAIN,     18'd76309);
                write_reg(CFG_RED_FROM_V,    18'd117489);
                write_reg(CFG_GREEN_FROM_U,  18'd13975);
                write_reg(CFG_GREEN_FROM_V,  18'd34925);
                write_reg(CFG_BLUE_FROM_U,   18'd138438);
                write_reg(CFG_LUMA_OFFSET,   18'd64);
                write_reg(CFG_CHROMA_OFFSET, 18'd512);
            end
            default: begin
                write_reg(CFG_LUMA_GAIN,     rand_coef(RST_LUMA_GAIN));
                write_reg(CFG_RED_FROM_V,    rand_coef(RST_RED_FROM_V));
                write_reg(CFG_GREEN_FROM_U,  rand_coef(RST_GREEN_FROM_U));
                write_reg(CFG_GREEN_FROM_V,  rand_coef(RST_GREEN_FROM_V));
                write_reg(CFG_BLUE_FROM_U,   rand_coef(RST_BLUE_FROM_U));
                write_reg(CFG_LUMA_OFFSET,   rand_offset());
                write_reg(CFG_CHROMA_OFFSET, rand_offset());
                if ($urandom_range(0, 1) == 0)
                    write_reg(CFG_NO_REG, CFG_DATA_W'($urandom));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int p, k, r;
        logic [COUNT_W-1:0] cnt;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain();
                load_setting(p);
                settings_used++;
            end
            if (p == 0) begin
                // Extremes under the reset coefficients.
                push_item('0, '0, '0, '0, 2'd2);
                push_item(SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP, 2'd2);
                push_item(SAMPLE_TOP, '0, 10'd128, 10'd128, 2'd2);
                push_item('0, SAMPLE_TOP, 10'd128, 10'd128, 2'd3);
                push_item(10'd512, 10'd100, 10'd300, 10'd700, 2'd0);
                push_item('0, '0, '0, '0, 2'd0);
                push_item(10'd200, SAMPLE_TOP, 10'd128, 10'd128, 2'd1);
                push_item(10'd700, '0, 10'd512, 10'd900, 2'd1);
                push_item(10'd128, 10'd128, '0, SAMPLE_TOP, 2'd2);
                push_item(10'd128, 10'd128, SAMPLE_TOP, '0, 2'd2);
                push_item(SAMPLE_TOP, SAMPLE_TOP, '0, '0, 2'd2);
                push_item('0, '0, SAMPLE_TOP, SAMPLE_TOP, 2'd2);
                push_item(10'd255, 10'd256, 10'd128, 10'd128, 2'd2);
                push_item(10'd235, 10'd16, 10'd240, 10'd16, 2'd3);
                push_item(SAMPLE_TOP, '0, SAMPLE_TOP, '0, 2'd1);
                push_item('0, SAMPLE_TOP, '0, SAMPLE_TOP, 2'd3);
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                r = $urandom_range(0, 19);
                if (r < 9)       cnt = 2'd2;
                else if (r < 16) cnt = 2'd1;
                else if (r < 18) cnt = 2'd0;
                else             cnt = 2'd3;
                push_item(rand_sample(), rand_sample(), rand_sample(), rand_sample(), cnt);
            end
        end
        drain();

        $display("tb: %0d inputs (%0d empty, %0d single, %0d pair, %0d count three)",
                 accepted_cnt, empty_cnt, single_cnt, pair_cnt, saturated_cnt);
        $display("tb: %0d pixels checked under %0d register settings, %0d mismatches",
                 pixels_checked, settings_used, errors);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("%0t: run did not finish in time", $time);
        $display("tb: failure");
        $finish;
    end

endmodule
